// ----- rtl/cpcf_pkg.sv -----
package cpcf_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int PAYLOAD_BYTES = 8;
	localparam int ID_W          = 29;
	localparam int DATA_W        = 8 * PAYLOAD_BYTES;

	localparam logic OP_LEARN = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic [1:0] ST_KNOWN = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// frame travelling down the row, with what the cells found so far
	typedef struct packed {
		logic              opcode;
		logic [ID_W-1:0]   msg_id;
		logic [DATA_W-1:0] payload;
		logic              hit;
		logic              stored;
		logic              forward;
	} item_t;

	function automatic logic [PAYLOAD_BYTES-1:0] byte_diff(
		input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b
	);
		logic [DATA_W-1:0]        x;
		logic [PAYLOAD_BYTES-1:0] m;
		x = a ^ b;
		m = '0;
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			m[k] = |x[8*k +: 8];
		end
		return m;
	endfunction

endpackage

// ----- rtl/cpcf_cell.sv -----
module cpcf_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           in_vld,
	input  cpcf_pkg::item_t in_item,
	output logic           out_vld,
	output cpcf_pkg::item_t out_item
);

	logic                                 ent_vld_q;
	logic [cpcf_pkg::ID_W-1:0]            ent_id_q;
	logic [cpcf_pkg::DATA_W-1:0]          ent_ref_q;
	logic [cpcf_pkg::PAYLOAD_BYTES-1:0]   ent_mask_q;

	logic                                 vld_q;
	cpcf_pkg::item_t                      item_q;

	logic                                 pending;
	logic                                 match;
	logic                                 take;
	logic [cpcf_pkg::PAYLOAD_BYTES-1:0]   diff;
	cpcf_pkg::item_t                      item_d;

	assign pending = in_vld && !in_item.hit && !in_item.stored;
	assign match   = pending && ent_vld_q && (ent_id_q == in_item.msg_id);
	assign take    = pending && !ent_vld_q && (in_item.opcode == cpcf_pkg::OP_LEARN);
	assign diff    = cpcf_pkg::byte_diff(ent_ref_q, in_item.payload);

	always_comb begin
		item_d = in_item;
		if (match) begin
			item_d.hit = 1'b1;
			if (in_item.opcode == cpcf_pkg::OP_CHECK) begin
				item_d.forward = |(diff & ~ent_mask_q);
			end
		end
		if (take) begin
			item_d.stored = 1'b1;
		end
	end

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else if (advance && take) begin
			ent_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (take) begin
				ent_id_q   <= in_item.msg_id;
				ent_ref_q  <= in_item.payload;
				ent_mask_q <= '0;
			end else if (match && in_item.opcode == cpcf_pkg::OP_LEARN) begin
				ent_mask_q <= ent_mask_q | diff;
			end
		end
	end

	// hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= item_d;
		end
	end

	assign out_vld  = vld_q;
	assign out_item = item_q;

	a_hit_or_store: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> !(item_q.hit && item_q.stored))
		else $error("beat both matched and stored");

	a_entry_kept: assert property (@(posedge clk) disable iff (!arst_n)
		ent_vld_q |=> ent_vld_q)
		else $error("entry lost");

	a_new_mask_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ent_vld_q) |-> (ent_mask_q == '0))
		else $error("new entry mask not clear");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && ent_vld_q) |=> $stable(ent_mask_q))
		else $error("mask changed during stall");

endmodule

// ----- rtl/can_payload_change_filter.sv -----
// channel | handshake            | fields                  | beat
// input   | in_valid, in_ready   | opcode, msg_id, payload | one frame to learn or check
// output  | out_valid, out_ready | forward, status         | one result per frame
//
// each frame walks the row of entry cells, one cell per cycle while the row advances
// from accept to result a frame passes through every cell register, then the output register
// a new frame can enter every cycle while results are taken
// a held result stalls the whole row, including input
// reset empties the table at once
module can_payload_change_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [cpcf_pkg::ID_W-1:0]          msg_id,
	input  logic [cpcf_pkg::DATA_W-1:0]        payload,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               forward,
	output logic [1:0]                         status
);

	logic                  advance;
	logic                  vld_chain  [0:cpcf_pkg::TABLE_ENTRIES];
	cpcf_pkg::item_t       item_chain [0:cpcf_pkg::TABLE_ENTRIES];

	logic                  out_valid_q;
	logic                  forward_q;
	logic [1:0]            status_q;
	cpcf_pkg::item_t       last;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	assign vld_chain[0]          = in_valid;
	assign item_chain[0].opcode  = opcode;
	assign item_chain[0].msg_id  = msg_id;
	assign item_chain[0].payload = payload;
	assign item_chain[0].hit     = 1'b0;
	assign item_chain[0].stored  = 1'b0;
	assign item_chain[0].forward = 1'b0;

	for (genvar i = 0; i < cpcf_pkg::TABLE_ENTRIES; i++) begin : g_cell
		cpcf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_vld   (vld_chain[i]),
			.in_item  (item_chain[i]),
			.out_vld  (vld_chain[i+1]),
			.out_item (item_chain[i+1])
		);
	end

	assign last = item_chain[cpcf_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_chain[cpcf_pkg::TABLE_ENTRIES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (last.opcode == cpcf_pkg::OP_CHECK) begin
				forward_q <= !last.hit || last.forward;
				status_q  <= cpcf_pkg::ST_KNOWN;
			end else begin
				forward_q <= 1'b0;
				if (last.hit) begin
					status_q <= cpcf_pkg::ST_KNOWN;
				end else if (last.stored) begin
					status_q <= cpcf_pkg::ST_NEW;
				end else begin
					status_q <= cpcf_pkg::ST_FULL;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign forward   = forward_q;
	assign status    = status_q;

endmodule
